// File: rtl/core/sit_pkg.sv
package sit_pkg;

	// coordinate width the block is built for unless told otherwise
	localparam int COORD_BITS_DEF = 16;

	// tolerance register, Q16 fraction
	localparam int TOL_BITS = 16;
	localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd655;

	// line parameter t: one integer bit above sixteen fraction bits
	localparam int Q_BITS = 17;
	localparam int ONE_Q16 = 65536;

	// intersection point, Q8, saturated to this signed width
	localparam int OUT_BITS = 26;
	localparam int OUT_MAX = 2 ** (OUT_BITS - 1) - 1;
	localparam int OUT_MIN = -(2 ** (OUT_BITS - 1));
	localparam int OUT_DATA_W = ((2 * OUT_BITS + 7) / 8) * 8;

endpackage

// File: rtl/core/segment_intersection_test.sv
// channel   | group      | contents (lowest bits first)
// ----------+------------+---------------------------------------------------------
// segments  | s_t*       | tdata: a_start_x a_start_y a_end_x a_end_y b_start_x
//           |            |        b_start_y b_end_x b_end_y (COORD_BITS each)
// result    | m_t*       | tuser: hit; tdata: cross_x cross_y (26 bits each), zero pad
// tolerance | cfg_we/... | cfg_wdata: tolerance_q16
//
// one segment pair per cycle while no result is held at the output
// most of the depth comes from the 17-step restoring divider that forms t, one quotient bit a stage
// reset clears the valid bits and sets tolerance_q16 to 655
// a stalled result holds every stage; s_tready is low only while the result waits
module segment_intersection_test #(
	parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sit_pkg::TOL_BITS-1:0]    cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
	input  logic [8*COORD_BITS-1:0]         s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// cross_x, cross_y, zero pad
	output logic [sit_pkg::OUT_DATA_W-1:0]  m_tdata,
	// hit
	output logic                            m_tuser
);
	import sit_pkg::*;

	localparam int CW   = COORD_BITS;
	localparam int DW   = CW + 1;
	localparam int PW   = 2 * CW + 2;
	localparam int MW   = 2 * CW + 2;
	localparam int SKW  = PW + Q_BITS;
	localparam int TW   = Q_BITS + 1;
	localparam int MTW  = DW + TW;
	localparam int PXW  = CW + 12;
	localparam int UXW  = PXW + 1;
	localparam int MUW  = UXW + DW;
	localparam int UW   = MUW + 1;
	localparam int CMPW = UW + 8;
	localparam int XW   = (PXW > OUT_BITS) ? PXW + 1 : OUT_BITS + 1;

	localparam int ST_DIFF = 0;
	localparam int ST_MUL  = 1;
	localparam int ST_SUM  = 2;
	localparam int ST_MAG  = 3;
	localparam int ST_DIV0 = 4;
	localparam int ST_SIGN = ST_DIV0 + Q_BITS;
	localparam int ST_TMUL = ST_SIGN + 1;
	localparam int ST_PX   = ST_TMUL + 1;
	localparam int ST_UXY  = ST_PX + 1;
	localparam int ST_UMUL = ST_UXY + 1;
	localparam int ST_USUM = ST_UMUL + 1;
	localparam int ST_OUT  = ST_USUM + 1;
	localparam int NST     = ST_OUT + 1;

	typedef struct packed {
		logic                       miss;
		logic signed [CW-1:0]       ax;
		logic signed [CW-1:0]       ay;
		logic signed [CW-1:0]       bx;
		logic signed [CW-1:0]       by;
		logic signed [DW-1:0]       d1x;
		logic signed [DW-1:0]       d1y;
		logic signed [DW-1:0]       d2x;
		logic signed [DW-1:0]       d2y;
		logic signed [DW-1:0]       ex;
		logic signed [DW-1:0]       ey;
		logic signed [PW-1:0]       pa;
		logic signed [PW-1:0]       pb;
		logic signed [PW-1:0]       pc;
		logic signed [PW-1:0]       pd;
		logic signed [PW-1:0]       num;
		logic signed [PW-1:0]       den;
		logic [PW-1:0]              qx;
		logic [PW-1:0]              qy;
		logic [PW-1:0]              sq;
		logic                       neg;
		logic [MW-1:0]              rem;
		logic [MW-1:0]              ad;
		logic [SKW-1:0]             sqk;
		logic [Q_BITS-1:0]          q;
		logic signed [TW-1:0]       t;
		logic signed [MTW-1:0]      mx1;
		logic signed [MTW-1:0]      my1;
		logic signed [PXW-1:0]      px;
		logic signed [PXW-1:0]      py;
		logic signed [UXW-1:0]      ux;
		logic signed [UXW-1:0]      uy;
		logic signed [MUW-1:0]      mux;
		logic signed [MUW-1:0]      muy;
		logic signed [UW-1:0]       u;
		logic                       hit;
		logic signed [OUT_BITS-1:0] ox;
		logic signed [OUT_BITS-1:0] oy;
	} item_t;

	// clamp a Q8 point to the output range
	function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [PXW-1:0] v);
		logic signed [XW-1:0] e;
		e = XW'(v);
		if (e > XW'(OUT_MAX))
			return OUT_BITS'(OUT_MAX);
		else if (e < XW'(OUT_MIN))
			return OUT_BITS'(OUT_MIN);
		else
			return OUT_BITS'(e);
	endfunction

	logic [TOL_BITS-1:0] tol_q;
	item_t               pipe_s [NST];
	logic [NST-1:0]      vld_s;
	logic                en;

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= TOL_RESET;
		else if (cfg_we)
			tol_q <= cfg_wdata;
	end

	// whole pipe advances unless the finished result is held
	assign en = !vld_s[NST-1] || m_tready;
	assign s_tready = en;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[NST-2:0], s_tvalid};
	end

	for (genvar k = 0; k < NST; k++) begin : g_stage
		item_t nxt;

		if (k == ST_DIFF) begin : g_diff
			// unpack and form direction vectors
			always_comb begin
				logic signed [CW-1:0] aex, aey, bex, bey;
				nxt = '0;
				nxt.ax = s_tdata[0*CW +: CW];
				nxt.ay = s_tdata[1*CW +: CW];
				aex    = s_tdata[2*CW +: CW];
				aey    = s_tdata[3*CW +: CW];
				nxt.bx = s_tdata[4*CW +: CW];
				nxt.by = s_tdata[5*CW +: CW];
				bex    = s_tdata[6*CW +: CW];
				bey    = s_tdata[7*CW +: CW];
				nxt.d1x = DW'(aex) - DW'(nxt.ax);
				nxt.d1y = DW'(aey) - DW'(nxt.ay);
				nxt.d2x = DW'(bex) - DW'(nxt.bx);
				nxt.d2y = DW'(bey) - DW'(nxt.by);
				nxt.ex  = DW'(nxt.bx) - DW'(nxt.ax);
				nxt.ey  = DW'(nxt.by) - DW'(nxt.ay);
			end
		end else if (k == ST_MUL) begin : g_mul
			// cross product terms and squared length terms
			always_comb begin
				nxt = pipe_s[k-1];
				nxt.pa = pipe_s[k-1].d1x * pipe_s[k-1].d2y;
				nxt.pb = pipe_s[k-1].d1y * pipe_s[k-1].d2x;
				nxt.pc = pipe_s[k-1].ex * pipe_s[k-1].d2y;
				nxt.pd = pipe_s[k-1].ey * pipe_s[k-1].d2x;
				nxt.qx = pipe_s[k-1].d2x * pipe_s[k-1].d2x;
				nxt.qy = pipe_s[k-1].d2y * pipe_s[k-1].d2y;
			end
		end else if (k == ST_SUM) begin : g_sum
			always_comb begin
				nxt = pipe_s[k-1];
				nxt.den = pipe_s[k-1].pa - pipe_s[k-1].pb;
				nxt.num = pipe_s[k-1].pc - pipe_s[k-1].pd;
				nxt.sq  = pipe_s[k-1].qx + pipe_s[k-1].qy;
			end
		end else if (k == ST_MAG) begin : g_mag
			// magnitudes and quotient sign; parallel segments miss
			always_comb begin
				nxt = pipe_s[k-1];
				nxt.miss = (pipe_s[k-1].den == '0);
				nxt.neg  = pipe_s[k-1].num[PW-1] ^ pipe_s[k-1].den[PW-1];
				nxt.ad   = pipe_s[k-1].den[PW-1] ? MW'(-pipe_s[k-1].den) : MW'(pipe_s[k-1].den);
				nxt.rem  = pipe_s[k-1].num[PW-1] ? MW'(-pipe_s[k-1].num) : MW'(pipe_s[k-1].num);
			end
		end else if (k == ST_DIV0) begin : g_div0
			// range precheck, integer quotient bit, right-hand bound of the u test
			always_comb begin
				logic [Q_BITS-1:0] kt;
				nxt = pipe_s[k-1];
				kt  = Q_BITS'(ONE_Q16) - Q_BITS'(tol_q);
				if ({1'b0, pipe_s[k-1].rem} >= {pipe_s[k-1].ad, 1'b0})
					nxt.miss = 1'b1;
				nxt.q = '0;
				if (pipe_s[k-1].rem >= pipe_s[k-1].ad) begin
					nxt.q[0] = 1'b1;
					nxt.rem  = pipe_s[k-1].rem - pipe_s[k-1].ad;
				end
				nxt.sqk = SKW'(pipe_s[k-1].sq) * SKW'(kt);
			end
		end else if (k > ST_DIV0 && k < ST_SIGN) begin : g_div
			// one fraction bit of the restoring divider
			always_comb begin
				logic [MW-1:0] r2;
				nxt = pipe_s[k-1];
				r2  = {pipe_s[k-1].rem[MW-2:0], 1'b0};
				nxt.q = {pipe_s[k-1].q[Q_BITS-2:0], 1'b0};
				if (r2 >= pipe_s[k-1].ad) begin
					r2 = r2 - pipe_s[k-1].ad;
					nxt.q[0] = 1'b1;
				end
				nxt.rem = r2;
			end
		end else if (k == ST_SIGN) begin : g_sign
			always_comb begin
				logic signed [TW-1:0] tq;
				nxt = pipe_s[k-1];
				tq  = {1'b0, pipe_s[k-1].q};
				nxt.t = pipe_s[k-1].neg ? -tq : tq;
			end
		end else if (k == ST_TMUL) begin : g_tmul
			// tolerance window on t and the scaled direction
			always_comb begin
				logic signed [TW:0] te, tlo, thi;
				nxt = pipe_s[k-1];
				te  = (TW + 1)'(pipe_s[k-1].t);
				tlo = -$signed({3'b000, tol_q});
				thi = $signed((TW + 1)'(ONE_Q16)) + $signed({3'b000, tol_q});
				if (te < tlo || te > thi)
					nxt.miss = 1'b1;
				nxt.mx1 = pipe_s[k-1].d1x * pipe_s[k-1].t;
				nxt.my1 = pipe_s[k-1].d1y * pipe_s[k-1].t;
			end
		end else if (k == ST_PX) begin : g_px
			// divide by 256 toward zero and add the start point in Q8
			always_comb begin
				logic signed [MTW-1:0] bx1, by1, rx, ry;
				nxt = pipe_s[k-1];
				bx1 = '0;
				by1 = '0;
				if (pipe_s[k-1].mx1[MTW-1])
					bx1[7:0] = 8'hFF;
				if (pipe_s[k-1].my1[MTW-1])
					by1[7:0] = 8'hFF;
				rx = pipe_s[k-1].mx1 + bx1;
				ry = pipe_s[k-1].my1 + by1;
				nxt.px = (PXW'(pipe_s[k-1].ax) <<< 8) + PXW'(rx >>> 8);
				nxt.py = (PXW'(pipe_s[k-1].ay) <<< 8) + PXW'(ry >>> 8);
			end
		end else if (k == ST_UXY) begin : g_uxy
			always_comb begin
				nxt = pipe_s[k-1];
				nxt.ux = UXW'(pipe_s[k-1].px) - (UXW'(pipe_s[k-1].bx) <<< 8);
				nxt.uy = UXW'(pipe_s[k-1].py) - (UXW'(pipe_s[k-1].by) <<< 8);
			end
		end else if (k == ST_UMUL) begin : g_umul
			always_comb begin
				nxt = pipe_s[k-1];
				nxt.mux = pipe_s[k-1].ux * pipe_s[k-1].d2x;
				nxt.muy = pipe_s[k-1].uy * pipe_s[k-1].d2y;
			end
		end else if (k == ST_USUM) begin : g_usum
			always_comb begin
				nxt = pipe_s[k-1];
				nxt.u = UW'(pipe_s[k-1].mux) + UW'(pipe_s[k-1].muy);
			end
		end else begin : g_out
			// projection test on segment b, then saturate or zero the point
			always_comb begin
				logic signed [UW-1:0] tsh;
				logic [CMPW-1:0]      ul, sl;
				logic                 m;
				nxt = pipe_s[k-1];
				tsh = UW'($signed({1'b0, tol_q[TOL_BITS-1:8]}));
				ul  = {pipe_s[k-1].u, 8'b0};
				sl  = CMPW'(pipe_s[k-1].sqk);
				m   = pipe_s[k-1].miss;
				if (pipe_s[k-1].u[UW-1]) begin
					if (pipe_s[k-1].u < -tsh)
						m = 1'b1;
				end else begin
					if (ul >= sl)
						m = 1'b1;
				end
				nxt.hit = !m;
				nxt.ox  = m ? '0 : sat_out(pipe_s[k-1].px);
				nxt.oy  = m ? '0 : sat_out(pipe_s[k-1].py);
			end
		end

		// stage register
		always_ff @(posedge clk) begin
			if (en)
				pipe_s[k] <= nxt;
		end
	end

	// result channel
	assign m_tvalid = vld_s[NST-1];
	assign m_tuser  = pipe_s[NST-1].hit;
	assign m_tdata  = {{(OUT_DATA_W - 2 * OUT_BITS){1'b0}}, pipe_s[NST-1].oy, pipe_s[NST-1].ox};

endmodule

// File: rtl/core/sit_check.sv
module sit_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [sit_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic                            m_tuser
);
	import sit_pkg::*;

	// a held result keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a miss carries a zero point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss with nonzero point");

	// input is refused only while a result waits
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input refused without output stall");

	// an empty output stage never blocks input
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

endmodule

bind segment_intersection_test sit_check u_sit_check (.*);

// File: bench/segment_intersection_test_tb.sv
`timescale 1ns / 100ps

module segment_intersection_test_tb;
	import sit_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int LATENCY = 28;
	localparam int N_RANDOM = 1350;

	typedef struct packed {
		logic [CB-1:0] bey, bex, bsy, bsx, aey, aex, asy, asx;
	} seg_pair_t;

	typedef struct {
		logic hit;
		logic signed [OUT_BITS-1:0] px;
		logic signed [OUT_BITS-1:0] py;
	} isect_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [TOL_BITS-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	// a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
	logic [8*CB-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	// cross_x, cross_y, zero pad
	logic [OUT_DATA_W-1:0] m_tdata;
	// hit
	logic m_tuser;

	segment_intersection_test #(.COORD_BITS(CB)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	isect_t pending_hits[$];
	int errors = 0;
	logic [15:0] tol_q16;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit recv_hold = 0;

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// intersection predictor
	function automatic isect_t predict_isect(seg_pair_t s, logic [15:0] tolv);
		isect_t r;
		longint ax, ay, bx, by, d1x, d1y, d2x, d2y, tol, den, num, t, px, py, u, sq;
		longint unsigned an, ad, q, rem;
		logic [127:0] lhs, rhs;
		r.hit = 0; r.px = 0; r.py = 0;
		ax = $signed(s.asx); ay = $signed(s.asy);
		bx = $signed(s.bsx); by = $signed(s.bsy);
		d1x = longint'($signed(s.aex)) - ax; d1y = longint'($signed(s.aey)) - ay;
		d2x = longint'($signed(s.bex)) - bx; d2y = longint'($signed(s.bey)) - by;
		tol = tolv;
		den = d1x * d2y - d1y * d2x;
		if (den == 0) return r;
		num = (bx - ax) * d2y - (by - ay) * d2x;
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		if (an >= 2 * ad) return r;
		q = 0; rem = an;
		if (rem >= ad) begin q = 1; rem -= ad; end
		for (int i = 0; i < 16; i++) begin
			rem <<= 1; q <<= 1;
			if (rem >= ad) begin rem -= ad; q |= 1; end
		end
		t = q;
		if ((num < 0) != (den < 0)) t = -t;
		if (t < -tol || t > 65536 + tol) return r;
		// division truncates toward zero as in c
		px = ax * 256 + (d1x * t) / 256;
		py = ay * 256 + (d1y * t) / 256;
		u = (px - bx * 256) * d2x + (py - by * 256) * d2y;
		if (u < 0) begin
			if (-u > (tol >>> 8)) return r;
		end else begin
			sq = d2x * d2x + d2y * d2y;
			lhs = 128'(u) * 128'd256;
			rhs = 128'(sq) * 128'(65536 - tol);
			if (lhs >= rhs) return r;
		end
		r.hit = 1;
		r.px = OUT_BITS'(px > OUT_MAX ? OUT_MAX : (px < OUT_MIN ? OUT_MIN : px));
		r.py = OUT_BITS'(py > OUT_MAX ? OUT_MAX : (py < OUT_MIN ? OUT_MIN : py));
		return r;
	endfunction

	function automatic seg_pair_t mk(int ax, int ay, int ex, int ey,
			int bx, int by, int fx, int fy);
		seg_pair_t s;
		s.asx = CB'(ax); s.asy = CB'(ay); s.aex = CB'(ex); s.aey = CB'(ey);
		s.bsx = CB'(bx); s.bsy = CB'(by); s.bex = CB'(fx); s.bey = CB'(fy);
		return s;
	endfunction

	// one item, with random idle ahead of it
	task automatic send_pair(seg_pair_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= s;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_hits.push_back(predict_isect(s, tol_q16));
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (pending_hits.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_tol(logic [15:0] v);
		cfg_we <= 1; cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		tol_q16 = v;
	endtask

	function automatic logic [15:0] rnd_coord();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(64)) - 32);
			2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
			default: return 16'($signed($urandom_range(2000)) - 1000);
		endcase
	endfunction

	// crossing pairs built around a random point so most items hit
	function automatic seg_pair_t rnd_pair();
		seg_pair_t s;
		int cx, cy, r;
		if ($urandom_range(9) < 3) begin
			s = {$urandom, $urandom, $urandom, $urandom};
			if ($urandom_range(1)) s.asx = rnd_coord();
			if ($urandom_range(1)) s.bey = rnd_coord();
			return s;
		end
		r = $urandom_range(1) ? 300 : 16000;
		cx = $signed($urandom_range(2 * r)) - r;
		cy = $signed($urandom_range(2 * r)) - r;
		s.asx = CB'(cx - $urandom_range(r)); s.asy = CB'(cy - $urandom_range(r));
		s.aex = CB'(cx + $urandom_range(r)); s.aey = CB'(cy + $urandom_range(r));
		s.bsx = CB'(cx + $urandom_range(r)); s.bsy = CB'(cy - $urandom_range(r));
		s.bex = CB'(cx - $urandom_range(r)); s.bey = CB'(cy + $urandom_range(r));
		return s;
	endfunction

	// result checking
	always @(posedge clk) begin
		isect_t e;
		logic signed [OUT_BITS-1:0] gx, gy;
		if (arst_n && m_tvalid && m_tready) begin
			gx = m_tdata[OUT_BITS-1:0];
			gy = m_tdata[2*OUT_BITS-1:OUT_BITS];
			if (pending_hits.size() == 0) begin
				$display("%0t: unexpected transfer hit=%b x=%0d y=%0d", $time, m_tuser, gx, gy);
				errors++;
			end else begin
				e = pending_hits.pop_front();
				if (m_tuser !== e.hit) begin
					$display("%0t: hit expected %b actual %b", $time, e.hit, m_tuser);
					errors++;
				end
				if (gx !== e.px) begin
					$display("%0t: cross_x expected %0d actual %0d", $time, e.px, gx);
					errors++;
				end
				if (gy !== e.py) begin
					$display("%0t: cross_y expected %0d actual %0d", $time, e.py, gy);
					errors++;
				end
				if (m_tdata[OUT_DATA_W-1:2*OUT_BITS] !== '0) begin
					$display("%0t: pad expected 0 actual %h", $time, m_tdata);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (recv_hold) m_tready <= 0;
		else m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// directed rows: pairs, typed result where obvious
	typedef struct {
		seg_pair_t s;
		bit known;
		isect_t r;
	} dir_row_t;

	initial begin
		dir_row_t rows[$];
		dir_row_t d;
		arst_n = 0; cfg_we = 0; cfg_wdata = 0; s_tvalid = 0; s_tdata = 0;
		tol_q16 = TOL_RESET;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// cross at origin, t = 0.5
		d.s = mk(-10, 0, 10, 0, 0, -10, 0, 10); d.known = 1;
		d.r.hit = 1; d.r.px = 0; d.r.py = 0; rows.push_back(d);
		// parallel
		d.s = mk(0, 0, 10, 0, 0, 5, 10, 5); d.r.hit = 0; rows.push_back(d);
		// zero length segment
		d.s = mk(3, 3, 3, 3, 0, 0, 9, 9); rows.push_back(d);
		d.s = mk(0, 0, 9, 9, 4, 4, 4, 4); rows.push_back(d);
		// t far out of range
		d.s = mk(0, 0, 1, 0, 100, -5, 100, 5); rows.push_back(d);
		// t = -0.5, beyond the tolerance, with the crossing inside B
		d.s = mk(0, 0, 10, 0, -5, -10, -5, 10); rows.push_back(d);
		// endpoint touches: t = 1, t = 0, u = 0, u = 1
		d.known = 0;
		d.s = mk(0, 0, 10, 0, 10, -10, 10, 10); rows.push_back(d);
		d.s = mk(0, 0, 10, 0, 0, 0, 0, 10); rows.push_back(d);
		d.s = mk(0, 0, 10, 0, 5, 0, 5, 10); rows.push_back(d);
		d.s = mk(0, 0, 10, 0, 5, 10, 5, 0); rows.push_back(d);
		// extremes, saturation and full range
		d.s = mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768); rows.push_back(d);
		d.s = mk(32767, 0, -32768, 0, 0, 32767, 0, -32768); rows.push_back(d);
		d.s = mk(-32768, 32767, 32767, 32767, 32767, -32768, 32767, 32767); rows.push_back(d);
		d.s = mk(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767); rows.push_back(d);
		d.s = mk(-1, -1, 1, 1, 1, -1, -1, 1); rows.push_back(d);
		d.s = mk(0, 0, 3, 1, 1, 0, 2, 7); rows.push_back(d);

		send_idle_pct = 24; recv_idle_pct = 87;
		foreach (rows[i]) begin
			send_pair(rows[i].s);
			if (rows[i].known) pending_hits[$] = rows[i].r;
		end
		drain();

		// tolerance extremes, middles, random; random items, idling swapped then off
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_tol(16'd0);
				1: write_tol(16'hffff);
				2: write_tol(16'd655);
				3: write_tol(16'h8000);
				4: write_tol(16'($urandom));
				default: write_tol(16'd655);
			endcase
			send_idle_pct = ph < 2 ? 24 : (ph < 4 ? 87 : 0);
			recv_idle_pct = ph < 2 ? 87 : (ph < 4 ? 24 : 0);
			if (ph == 4) begin
				// long receiver stall while the sender keeps offering
				fork
					begin
						recv_hold = 1;
						repeat (200) @(negedge clk);
						recv_hold = 0;
					end
				join_none
			end
			for (int i = 0; i < N_RANDOM / 6; i++) send_pair(rnd_pair());
			drain();
		end

		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	// run limit
	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
